### src/asmtok_pkg.sv
`timescale 1ns / 1ps
// asmtok_pkg: token codes, scanner modes, result records and sizes shared by
// the assembler token scanner modules. No dependencies.
package asmtok_pkg;

  localparam int LABEL_MAX   = 32;
  localparam int LEN_W       = 6;
  localparam int ACC_W       = 17;
  localparam int NV_W        = ACC_W + 5;
  localparam int LIMIT_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACC_W-1:0]     ACC_MAX           = '1;
  localparam logic [LIMIT_W-1:0]   SMALL_LIMIT_RESET = 16'd255;
  localparam logic [LIMIT_W-1:0]   BIG_LIMIT_RESET   = 16'd65535;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_LIMIT     = 2'd1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5a;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [3:0] DIGIT_TEN = 4'd10;

  typedef enum logic [3:0] {
    KIND_ICHAR  = 4'd0,
    KIND_IEND   = 4'd1,
    KIND_NUM8   = 4'd2,
    KIND_NUM16  = 4'd3,
    KIND_COLON  = 4'd4,
    KIND_COMMA  = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_DOLLAR = 4'd8,
    KIND_ERROR  = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_LABEL_LEN = 2'd1,
    ERR_TOO_BIG   = 2'd2,
    ERR_UNKNOWN   = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_ZERO    = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_HALT    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2
  } base_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   ch;
    logic         first;
    logic [15:0]  val;
    err_e         err;
  } result_t;

  // One accepted request's results: one or two records.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/asmtok_front.sv
`timescale 1ns / 1ps
// asmtok_front: accepts source bytes, runs the scanner state and the limit
// registers, and pushes each request's results as one bundle. Uses asmtok_pkg.
module asmtok_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       char_byte_i,
  input  logic                             end_of_text_i,
  input  logic                             cfg_we_i,
  input  logic [asmtok_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asmtok_pkg::LIMIT_W-1:0]   cfg_data_i,
  input  asmtok_pkg::q_stat_t              q_stat_i,
  output logic                             push_o,
  output asmtok_pkg::bundle_t              push_data_o
);
  import asmtok_pkg::*;

  mode_e                mode_q, mode_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  base_e                base_q, base_d;
  logic [LIMIT_W-1:0]   small_q, big_q;

  logic [7:0]           c;
  logic                 eot, accept;
  logic                 is_letter, is_digit, is_alnum, digit_ok;
  logic [3:0]           dval;
  logic [NV_W-1:0]      acc_x, mul, nv;
  logic [ACC_W-1:0]     acc_sat;
  logic                 acc_ovf, fin_err, len_full;
  result_t              fin_res;

  logic                 idl_emit, idl_ident, idl_start;
  result_t              idl_res;
  mode_e                idl_mode;
  logic [ACC_W-1:0]     idl_acc;

  logic                 any, use_idle, idle_slot1;
  result_t              res0, res1;
  logic                 two;

  assign c        = char_byte_i;
  assign eot      = end_of_text_i | (c == CH_NUL);
  assign accept   = in_valid_i & in_ready_o;
  assign in_ready_o = ~q_stat_i.full;

  assign is_letter = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
                     || (c == CH_USCORE);
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_alnum  = is_letter | is_digit;
  assign len_full  = len_q >= LEN_W'(LABEL_MAX - 1);

  always_comb begin
    digit_ok = 1'b1;
    dval     = '0;
    if (is_digit) begin
      dval = 4'(c - CH_ZERO);
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      dval = 4'(c - CH_LA) + DIGIT_TEN;
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      dval = 4'(c - CH_UA) + DIGIT_TEN;
    end else begin
      digit_ok = 1'b0;
    end
  end

  // Constant-base multiply as shifts and adds.
  assign acc_x = NV_W'(acc_q);
  always_comb begin
    unique case (base_q)
      BASE_HEX: mul = acc_x << 4;
      BASE_BIN: mul = acc_x << 1;
      default:  mul = (acc_x << 3) + (acc_x << 1);
    endcase
  end
  assign nv      = mul + NV_W'(dval);
  assign acc_sat = (nv > NV_W'(ACC_MAX)) ? ACC_MAX : nv[ACC_W-1:0];
  assign acc_ovf = nv > NV_W'(big_q);
  assign fin_err = ovf_q | (acc_q > ACC_W'(big_q));

  always_comb begin
    fin_res = '0;
    if (fin_err) begin
      fin_res.kind = KIND_ERROR;
      fin_res.err  = ERR_TOO_BIG;
    end else begin
      fin_res.kind = (acc_q <= ACC_W'(small_q)) ? KIND_NUM8 : KIND_NUM16;
      fin_res.val  = acc_q[15:0];
    end
  end

  // Classify a byte as seen from idle.
  always_comb begin
    idl_emit  = 1'b0;
    idl_ident = 1'b0;
    idl_start = 1'b0;
    idl_res   = '0;
    idl_mode  = MODE_IDLE;
    idl_acc   = ACC_W'(dval);
    unique case (c)
      CH_SPACE, CH_NL, CH_TAB: ;
      CH_COLON:  begin idl_emit = 1'b1; idl_res.kind = KIND_COLON;  end
      CH_COMMA:  begin idl_emit = 1'b1; idl_res.kind = KIND_COMMA;  end
      CH_LPAREN: begin idl_emit = 1'b1; idl_res.kind = KIND_LPAREN; end
      CH_RPAREN: begin idl_emit = 1'b1; idl_res.kind = KIND_RPAREN; end
      CH_DOLLAR: begin idl_emit = 1'b1; idl_res.kind = KIND_DOLLAR; end
      CH_SEMI:   idl_mode = MODE_COMMENT;
      default: begin
        if (is_letter) begin
          idl_emit      = 1'b1;
          idl_ident     = 1'b1;
          idl_res.kind  = KIND_ICHAR;
          idl_res.ch    = c;
          idl_res.first = 1'b1;
          idl_mode      = MODE_IDENT;
        end else if (is_digit) begin
          idl_start = 1'b1;
          idl_mode  = (c == CH_ZERO) ? MODE_ZERO : MODE_NUMBER;
        end else begin
          idl_emit     = 1'b1;
          idl_res.kind = KIND_ERROR;
          idl_res.err  = ERR_UNKNOWN;
          idl_mode     = MODE_HALT;
        end
      end
    endcase
  end

  // Next scanner mode.
  always_comb begin
    mode_d = mode_q;
    if (eot) begin
      mode_d = MODE_IDLE;
    end else begin
      unique case (mode_q)
        MODE_IDLE:    mode_d = idl_mode;
        MODE_IDENT:   mode_d = is_alnum ? (len_full ? MODE_HALT : MODE_IDENT) : idl_mode;
        MODE_ZERO, MODE_NUMBER: begin
          if ((mode_q == MODE_ZERO) && ((c == CH_LX) || (c == CH_LB))) begin
            mode_d = MODE_NUMBER;
          end else if (digit_ok) begin
            mode_d = MODE_NUMBER;
          end else begin
            mode_d = fin_err ? MODE_HALT : idl_mode;
          end
        end
        MODE_COMMENT: mode_d = (c == CH_NL) ? MODE_IDLE : MODE_COMMENT;
        default:      mode_d = MODE_HALT;
      endcase
    end
  end

  // Results and datapath state.
  always_comb begin
    res0       = '0;
    res1       = '0;
    two        = 1'b0;
    any        = 1'b0;
    use_idle   = 1'b0;
    idle_slot1 = 1'b0;
    len_d      = len_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    base_d     = base_q;
    if (eot) begin
      if (mode_q == MODE_IDENT) begin
        res0.kind = KIND_IEND;
        any       = 1'b1;
      end else if ((mode_q == MODE_ZERO) || (mode_q == MODE_NUMBER)) begin
        res0 = fin_res;
        any  = 1'b1;
      end
      len_d = '0;
    end else begin
      unique case (mode_q)
        MODE_IDLE: use_idle = 1'b1;
        MODE_IDENT: begin
          any = 1'b1;
          if (is_alnum) begin
            if (len_full) begin
              res0.kind = KIND_ERROR;
              res0.err  = ERR_LABEL_LEN;
            end else begin
              res0.kind = KIND_ICHAR;
              res0.ch   = c;
              len_d     = len_q + LEN_W'(1);
            end
          end else begin
            res0.kind  = KIND_IEND;
            use_idle   = 1'b1;
            idle_slot1 = 1'b1;
          end
        end
        MODE_ZERO, MODE_NUMBER: begin
          if ((mode_q == MODE_ZERO) && (c == CH_LX)) begin
            acc_d  = '0;
            ovf_d  = 1'b0;
            base_d = BASE_HEX;
          end else if ((mode_q == MODE_ZERO) && (c == CH_LB)) begin
            acc_d  = '0;
            ovf_d  = 1'b0;
            base_d = BASE_BIN;
          end else if (digit_ok) begin
            acc_d = acc_sat;
            if (acc_ovf) ovf_d = 1'b1;
          end else begin
            res0 = fin_res;
            any  = 1'b1;
            if (!fin_err) begin
              use_idle   = 1'b1;
              idle_slot1 = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (use_idle) begin
      if (idl_emit) begin
        any = 1'b1;
        if (idle_slot1) begin
          res1 = idl_res;
          two  = 1'b1;
        end else begin
          res0 = idl_res;
        end
      end
      if (idl_ident) len_d = LEN_W'(1);
      if (idl_start) begin
        acc_d  = idl_acc;
        ovf_d  = 1'b0;
        base_d = BASE_DEC;
      end
    end
  end

  assign push_o           = accept & any;
  assign push_data_o.two  = two;
  assign push_data_o.r0   = res0;
  assign push_data_o.r1   = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      base_q <= BASE_DEC;
    end else if (accept) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_q <= SMALL_LIMIT_RESET;
      big_q   <= BIG_LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SMALL_LIMIT) small_q <= cfg_data_i;
      if (cfg_index_i == CFG_BIG_LIMIT)   big_q   <= cfg_data_i;
    end
  end

endmodule

### src/asmtok_queue.sv
`timescale 1ns / 1ps
// asmtok_queue: short FIFO of result bundles between scanner front and output
// back. Uses asmtok_pkg.
module asmtok_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  asmtok_pkg::bundle_t push_data_i,
  input  logic                pop_i,
  output asmtok_pkg::bundle_t pop_data_o,
  output asmtok_pkg::q_stat_t stat_o
);
  import asmtok_pkg::*;

  bundle_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  count_q;

  assign stat_o.full  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign stat_o.empty = count_q == '0;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + QCNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - QCNT_W'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full)) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty)) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

### src/asmtok_back.sv
`timescale 1ns / 1ps
// asmtok_back: pops result bundles and presents their records one at a time
// from an output register. Uses asmtok_pkg.
module asmtok_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asmtok_pkg::q_stat_t q_stat_i,
  input  asmtok_pkg::bundle_t pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          token_kind_o,
  output logic [7:0]          ident_char_o,
  output logic                ident_first_o,
  output logic [15:0]         number_value_o,
  output logic [1:0]          error_code_o,
  output logic                last_of_run_o
);
  import asmtok_pkg::*;

  bundle_t hold_q;
  logic    hold_v_q;
  logic    phase_q;
  logic    last;
  result_t cur;

  assign last  = phase_q | ~hold_q.two;
  assign pop_o = ~q_stat_i.empty & (~hold_v_q | (out_ready_i & last));
  assign cur   = phase_q ? hold_q.r1 : hold_q.r0;

  assign out_valid_o    = hold_v_q;
  assign token_kind_o   = cur.kind;
  assign ident_char_o   = cur.ch;
  assign ident_first_o  = cur.first;
  assign number_value_o = cur.val;
  assign error_code_o   = cur.err;
  assign last_of_run_o  = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) hold_q <= pop_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      phase_q  <= 1'b0;
    end else if (pop_o) begin
      hold_v_q <= 1'b1;
      phase_q  <= 1'b0;
    end else if (hold_v_q && out_ready_i) begin
      if (last) hold_v_q <= 1'b0;
      else      phase_q  <= 1'b1;
    end
  end

endmodule

### src/assembler_token_scanner.sv
`timescale 1ns / 1ps
// assembler_token_scanner: byte-serial assembler lexer, top level.
// Throughput: one source byte per cycle while the queue is not full; a byte that
// gives two tokens holds the output register for both, absorbed by a four-bundle
// queue. A byte's first token passes through the queue, then the output register.
// Reset (rst_ni low, asynchronous): scanner idle, limits 255 / 65535, queue
// and output register empty. Depends on asmtok_pkg, front, queue and back.
module assembler_token_scanner (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // source byte request
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       char_byte_i,
  input  logic                             end_of_text_i,
  // limit register writes
  input  logic                             cfg_we_i,
  input  logic [asmtok_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asmtok_pkg::LIMIT_W-1:0]   cfg_data_i,
  // token request
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [3:0]                       token_kind_o,
  output logic [7:0]                       ident_char_o,
  output logic                             ident_first_o,
  output logic [15:0]                      number_value_o,
  output logic [1:0]                       error_code_o,
  output logic                             last_of_run_o
);
  import asmtok_pkg::*;

  // Front to queue: a bundle per byte that yields any token.
  logic    push;
  bundle_t push_data;
  // Queue to back: head bundle, pop strobe, fill status.
  logic    pop;
  bundle_t pop_data;
  q_stat_t q_stat;

  // Classify the byte and advance the scanner in the cycle it is accepted;
  // stall only when the queue has no room.
  asmtok_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_byte_i   (char_byte_i),
    .end_of_text_i (end_of_text_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Decouple the scanner from output back-pressure.
  asmtok_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // Hand out the tokens of each bundle in order, flagging the last one.
  asmtok_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .ident_char_o   (ident_char_o),
    .ident_first_o  (ident_first_o),
    .number_value_o (number_value_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
